FILE: hw/rtl/bpct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpct_pkg
// Shared types and constants for the beacon parent candidate table.
// ----------------------------------------------------------------------------
package bpct_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_NOTE   = 2'd1,
    CMD_SELECT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic [0:0] REG_REQ_EXT = 1'd0;
  localparam logic [0:0] REG_JOIN    = 1'd1;

  localparam logic [1:0] JOIN_ROUTER = 2'd0;
  localparam logic [1:0] JOIN_END    = 2'd1;
  localparam logic [1:0] JOIN_RESET  = 2'd2;

  localparam logic [3:0] PROFILE_PRO = 4'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic        frame_valid;
    logic [7:0]  channel;
    logic [15:0] pan_id;
    logic [63:0] ext_pan_id;
    logic [15:0] short_addr;
    logic [7:0]  depth;
    logic [7:0]  lqi;
    logic signed [7:0] rssi;
    logic [2:0]  flags;
    logic [3:0]  stack_profile;
    logic [7:0]  update_id;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic        found;
    logic [7:0]  best_channel;
    logic [15:0] best_pan_id;
    logic [63:0] best_ext_pan_id;
    logic [15:0] best_short_addr;
    logic [7:0]  best_depth;
    logic [7:0]  best_lqi;
    logic signed [7:0] best_rssi;
    logic [7:0]  best_update_id;
    logic [3:0]  entry_count;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input item, reset scan trackers
    logic scan;     // evaluate current slot
    logic clear;    // empty the table
    logic write;    // write captured beacon into chosen slot
    logic finish;   // build the result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;     // current scan slot is the last one
    logic hit_low;  // same key held with better quality: stop, accept
    logic do_write; // scan concluded that the beacon is stored
  } dp_status_t;

endpackage

FILE: hw/rtl/bpct_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpct_item_if
// Valid/ready channel for input items.
// ----------------------------------------------------------------------------
interface bpct_item_if;
  import bpct_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/bpct_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpct_result_if
// Valid/ready channel for result items.
// ----------------------------------------------------------------------------
interface bpct_result_if;
  import bpct_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/bpct_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpct_ctrl
// Sequencer: capture, slot scan, write-back, result hand-off.
// ----------------------------------------------------------------------------
module bpct_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            command,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bpct_pkg::dp_cmd_t     cmd,
  input  bpct_pkg::dp_status_t  status
);
  import bpct_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_WRITE  = 6'b000100,
    S_FINISH = 6'b001000,
    S_OUT    = 6'b010000,
    S_CLEAR  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   is_note;

  wire take = in_valid && in_ready;

  // input is held off until the pending result has been transferred
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          cmd.load = 1'b1;
          if (command == CMD_CLEAR) state_next = S_CLEAR;
          else if (command == CMD_NOTE || command == CMD_SELECT) state_next = S_SCAN;
          else state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (is_note && status.hit_low) state_next = S_FINISH;
        else if (status.last) state_next = is_note ? S_WRITE : S_FINISH;
      end
      S_WRITE: begin
        cmd.write  = status.do_write;
        state_next = S_FINISH;
      end
      S_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      is_note <= 1'b0;
    end else begin
      state <= state_next;
      if (take) is_note <= (command == CMD_NOTE);
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_write_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> $past(state) == S_SCAN)
    else $error("write without scan");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
endmodule

FILE: hw/rtl/bpct_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpct_datapath
// Entry table, one-slot-per-cycle scan trackers and result register.
// ----------------------------------------------------------------------------
module bpct_datapath #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bpct_pkg::item_t       item,
  input  logic [63:0]           req_ext,
  input  logic [1:0]            join_as,
  input  bpct_pkg::dp_cmd_t     cmd,
  output bpct_pkg::dp_status_t  status,
  output bpct_pkg::result_t     result
);
  import bpct_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

  logic [TABLE_ENTRIES-1:0] used;
  logic [39:0] e_ident [TABLE_ENTRIES];
  logic [63:0] e_ext   [TABLE_ENTRIES];
  logic [23:0] e_qual  [TABLE_ENTRIES];
  logic [14:0] e_flag  [TABLE_ENTRIES];

  item_t       cap;
  logic [IW-1:0] idx;
  // note trackers
  logic          have_slot;
  logic [IW-1:0] slot;
  logic [IW-1:0] weak_slot;
  logic [7:0]    weak_lqi;
  logic          rejected;
  logic          hit_low_r;
  // select trackers
  logic          have_best;
  logic [IW-1:0] best;
  logic [7:0]    best_lqi;
  logic [7:0]    best_dep;
  result_t       res_next;

  wire [39:0] key = {cap.channel, cap.pan_id, cap.short_addr};
  wire [7:0]  cur_lqi = e_qual[idx][15:8];
  wire [7:0]  cur_dep = e_qual[idx][23:16];
  wire [2:0]  cur_fl  = e_flag[idx][14:12];
  wire        match   = used[idx] && (e_ident[idx] == key);
  wire        usable  = used[idx] && cur_fl[0] && (e_flag[idx][11:8] == PROFILE_PRO) &&
                        ((join_as == JOIN_ROUTER && cur_fl[1]) ||
                         (join_as == JOIN_END && cur_fl[2]));
  wire        better  = !have_best || (cur_lqi > best_lqi) ||
                        (cur_lqi == best_lqi && cur_dep < best_dep);
  wire        filt_ok = cap.frame_valid && (req_ext == '0 || cap.ext_pan_id == req_ext);
  wire [IW-1:0] wslot = have_slot ? slot : weak_slot;

  assign status.last     = (idx == LAST);
  assign status.hit_low  = match && (cap.lqi < cur_lqi);
  assign status.do_write = !rejected && !hit_low_r &&
                           (have_slot || (weak_lqi < cap.lqi));

  logic [CW-1:0] count;
  always_comb begin
    count = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) count = count + CW'(used[i]);
  end

  // result image; trackers are stable during the finish cycle
  always_comb begin
    res_next             = '0;
    res_next.entry_count = 4'(count);
    if (cap.command == CMD_NOTE)
      res_next.accepted = !rejected && (hit_low_r || status.do_write);
    if (cap.command == CMD_SELECT && have_best) begin
      res_next.found           = 1'b1;
      res_next.best_channel    = e_ident[best][39:32];
      res_next.best_pan_id     = e_ident[best][31:16];
      res_next.best_short_addr = e_ident[best][15:0];
      res_next.best_ext_pan_id = e_ext[best];
      res_next.best_depth      = e_qual[best][23:16];
      res_next.best_lqi        = e_qual[best][15:8];
      res_next.best_rssi       = e_qual[best][7:0];
      res_next.best_update_id  = e_flag[best][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.clear) begin
      used <= '0;
    end else if (cmd.write) begin
      used[wslot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cap       <= item;
      idx       <= '0;
      have_slot <= 1'b0;
      slot      <= '0;
      weak_slot <= '0;
      weak_lqi  <= 8'hFF;
      hit_low_r <= 1'b0;
      have_best <= 1'b0;
      best      <= '0;
      best_lqi  <= '0;
      best_dep  <= '0;
      rejected  <= 1'b0;
    end
    if (cmd.scan) begin
      if (idx == '0) rejected <= !filt_ok;
      if (idx != LAST) idx <= idx + 1'b1;
      // note: first match or first free slot; match wins and ends search
      if (!have_slot) begin
        if (match) begin
          have_slot <= 1'b1;
          slot      <= idx;
          hit_low_r <= cap.lqi < cur_lqi;
        end else if (!used[idx]) begin
          have_slot <= 1'b1;
          slot      <= idx;
        end
      end else if (match) begin
        // a match after a free slot still takes priority
        if (!used[slot]) begin
          slot      <= idx;
          hit_low_r <= cap.lqi < cur_lqi;
        end
      end
      if (idx == '0 || cur_lqi < weak_lqi) begin
        weak_slot <= idx;
        weak_lqi  <= cur_lqi;
      end
      if (usable && better) begin
        have_best <= 1'b1;
        best      <= idx;
        best_lqi  <= cur_lqi;
        best_dep  <= cur_dep;
      end
    end
    if (cmd.clear) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        e_ident[i] <= '0;
        e_ext[i]   <= '0;
        e_qual[i]  <= '0;
        e_flag[i]  <= '0;
      end
    end else if (cmd.write) begin
      e_ident[wslot] <= key;
      e_ext[wslot]   <= cap.ext_pan_id;
      e_qual[wslot]  <= {cap.depth, cap.lqi, cap.rssi};
      e_flag[wslot]  <= {cap.flags, cap.stack_profile, cap.update_id};
    end
    if (cmd.finish) result <= res_next;
  end
endmodule

FILE: hw/rtl/beacon_parent_candidate_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beacon_parent_candidate_table
// Scan-time table of heard beacons with best-parent selection.
// ----------------------------------------------------------------------------
// One item is handled at a time. A note or select command walks the table
// one slot per cycle. A note then passes a write-back step and a step that
// builds the result. A note whose key is already held with better link
// quality stops the walk at that slot. Select skips the write-back. Clear
// empties the table and then builds the result; the unused command code
// goes straight to building the result. The next input transfer is taken
// the cycle after the result transfer. Configuration must be written only
// while no item is in flight.
module beacon_parent_candidate_table #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  bpct_item_if.sink   in_ch,
  bpct_result_if.source out_ch
);
  import bpct_pkg::*;

  logic [63:0] req_ext;
  logic [1:0]  join_as;
  dp_cmd_t     cmd;
  dp_status_t  status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      req_ext <= '0;
      join_as <= JOIN_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_REQ_EXT) req_ext <= cfg_data;
      else join_as <= cfg_data[1:0];
    end
  end

  bpct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .command   (in_ch.data.command),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  bpct_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .item    (in_ch.data),
    .req_ext (req_ext),
    .join_as (join_as),
    .cmd     (cmd),
    .status  (status),
    .result  (out_ch.data)
  );
endmodule
